// ===== rtl/core/sg_pair_read_segmenter_macros.svh =====
// assertion macros used by sgp_ctrl of the segmenter rtl
// expects clk_i and rst_ni in the including module
`ifndef SG_PAIR_READ_SEGMENTER_MACROS_SVH
`define SG_PAIR_READ_SEGMENTER_MACROS_SVH

// property holds at every clock edge out of reset
`define SGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sgp_pkg.sv =====
// shared types, codes and widths of the scatter-gather pair read segmenter
// no dependencies
package sgp_pkg;

  localparam int unsigned LocalEntries  = 16;
  localparam int unsigned RemoteEntries = 16;
  localparam int unsigned IdxW          = 4;
  localparam int unsigned CntW          = 5;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned LenW          = 32;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned DoneW         = 36;
  localparam int unsigned PrefW         = 13;
  localparam int unsigned AccW          = 37;
  localparam int unsigned AluW          = 64;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned LocalWordW    = AddrW + LenW;
  localparam int unsigned RemoteWordW   = KeyW + AddrW + LenW;

  typedef enum logic [1:0] {
    ACT_LOAD_LOCAL  = 2'd0,
    ACT_LOAD_REMOTE = 2'd1,
    ACT_START       = 2'd2,
    ACT_NEXT        = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_SEG = 1'b0,
    CFG_PREFIX  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MIN = 2'd2
  } alu_op_e;

  typedef struct packed {
    action_e              action;
    logic [IdxW-1:0]      entry_index;
    logic [AddrW-1:0]     entry_addr;
    logic [LenW-1:0]      entry_len;
    logic [KeyW-1:0]      entry_key;
    logic [CntW-1:0]      local_count;
    logic [CntW-1:0]      remote_count;
    logic [DoneW-1:0]     bytes_done;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [AddrW-1:0]     seg_local_addr;
    logic [IdxW-1:0]      seg_local_entry;
    logic [AddrW-1:0]     seg_remote_addr;
    logic [KeyW-1:0]      seg_remote_key;
    logic [LenW-1:0]      seg_len;
    logic                 last_segment;
  } res_t;

  typedef struct packed {
    logic [LenW-1:0]      max_segment_len;
    logic [PrefW-1:0]     prefix_len;
  } cfg_t;

  typedef struct packed {
    alu_op_e              op;
    logic [AluW-1:0]      a;
    logic [AluW-1:0]      b;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0]      res;
    logic                 lt;
  } alu_rsp_t;

endpackage

// ===== rtl/core/sg_pair_read_segmenter.sv =====
// top level of the scatter-gather pair read segmenter
// depends on sgp_pkg, sgp_ram, sgp_alu and sgp_ctrl
//
// A request is taken when start is high and busy is low; a load of a local
// or remote entry writes its table and gives no result. A start walks both
// length tables and then locates both positions through one shared 64-bit
// add/subtract/min unit, one table entry per cycle. A next request steps the
// shared unit once per cycle through the length, minimum, address, sent and
// offset steps, plus a skip step per list whose entry is used up, which also
// passes empty entries; the sequencer is busy meanwhile. A next with nothing
// in flight answers the following cycle. Each result is shown for exactly one
// cycle on res_o with res_valid_o high; the receiver cannot stall it. The
// configuration port is always ready. The entry tables have no reset and must
// be loaded before they are used.
module sg_pair_read_segmenter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  sgp_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  output sgp_pkg::res_t                 res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sgp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sgp_pkg::LenW-1:0]      cfg_data_i
);

  localparam int unsigned LenW  = sgp_pkg::LenW;
  localparam int unsigned PrefW = sgp_pkg::PrefW;

  logic [LenW-1:0]  max_seg_q, max_seg_d;
  logic [PrefW-1:0] prefix_q, prefix_d;
  sgp_pkg::cfg_t    cfg;

  sgp_pkg::alu_req_t alu_req;
  sgp_pkg::alu_rsp_t alu_rsp;

  logic                              lwe, rwe;
  logic [sgp_pkg::IdxW-1:0]          lwaddr, lraddr, rwaddr, rraddr;
  logic [sgp_pkg::LocalWordW-1:0]    lwdata, lrdata;
  logic [sgp_pkg::RemoteWordW-1:0]   rwdata, rrdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    max_seg_d = max_seg_q;
    prefix_d  = prefix_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sgp_pkg::CFG_MAX_SEG: max_seg_d = cfg_data_i;
        sgp_pkg::CFG_PREFIX:  prefix_d  = cfg_data_i[PrefW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q <= '1;
      prefix_q  <= '0;
    end else begin
      max_seg_q <= max_seg_d;
      prefix_q  <= prefix_d;
    end
  end

  assign cfg.max_segment_len = max_seg_q;
  assign cfg.prefix_len      = prefix_q;

  sgp_ram #(
    .Width (sgp_pkg::LocalWordW),
    .Depth (sgp_pkg::LocalEntries)
  ) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwaddr),
    .wdata_i (lwdata),
    .raddr_i (lraddr),
    .rdata_o (lrdata)
  );

  sgp_ram #(
    .Width (sgp_pkg::RemoteWordW),
    .Depth (sgp_pkg::RemoteEntries)
  ) u_remote_ram (
    .clk_i   (clk_i),
    .we_i    (rwe),
    .waddr_i (rwaddr),
    .wdata_i (rwdata),
    .raddr_i (rraddr),
    .rdata_o (rrdata)
  );

  sgp_alu u_alu (
    .alu_req_i (alu_req),
    .alu_rsp_o (alu_rsp)
  );

  sgp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_i       (cfg),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .lwe_o       (lwe),
    .lwaddr_o    (lwaddr),
    .lwdata_o    (lwdata),
    .lraddr_o    (lraddr),
    .lrdata_i    (lrdata),
    .rwe_o       (rwe),
    .rwaddr_o    (rwaddr),
    .rwdata_o    (rwdata),
    .rraddr_o    (rraddr),
    .rrdata_i    (rrdata)
  );

endmodule

// ===== rtl/core/sgp_ram.sv =====
// generic single write, single registered read memory
// no dependencies
module sgp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sgp_alu.sv =====
// shared 64-bit add, subtract and minimum unit
// depends on sgp_pkg
module sgp_alu (
  input  sgp_pkg::alu_req_t alu_req_i,
  output sgp_pkg::alu_rsp_t alu_rsp_o
);

  localparam int unsigned AluW = sgp_pkg::AluW;

  logic [AluW:0] diff;

  assign diff = {1'b0, alu_req_i.a} - {1'b0, alu_req_i.b};

  always_comb begin
    alu_rsp_o.lt = diff[AluW];
    unique case (alu_req_i.op)
      sgp_pkg::ALU_ADD: alu_rsp_o.res = alu_req_i.a + alu_req_i.b;
      sgp_pkg::ALU_SUB: alu_rsp_o.res = diff[AluW-1:0];
      sgp_pkg::ALU_MIN: alu_rsp_o.res = diff[AluW] ? alu_req_i.a : alu_req_i.b;
      default:          alu_rsp_o.res = '0;
    endcase
  end

endmodule

// ===== rtl/core/sgp_ctrl.sv =====
// sequencer and segment state of the pair read segmenter
// depends on sgp_pkg, drives sgp_alu and both sgp_ram tables
`include "sg_pair_read_segmenter_macros.svh"

module sgp_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  sgp_pkg::req_t                       req_i,
  output logic                                res_valid_o,
  output sgp_pkg::res_t                       res_o,
  input  sgp_pkg::cfg_t                       cfg_i,
  output sgp_pkg::alu_req_t                   alu_req_o,
  input  sgp_pkg::alu_rsp_t                   alu_rsp_i,
  output logic                                lwe_o,
  output logic [sgp_pkg::IdxW-1:0]            lwaddr_o,
  output logic [sgp_pkg::LocalWordW-1:0]      lwdata_o,
  output logic [sgp_pkg::IdxW-1:0]            lraddr_o,
  input  logic [sgp_pkg::LocalWordW-1:0]      lrdata_i,
  output logic                                rwe_o,
  output logic [sgp_pkg::IdxW-1:0]            rwaddr_o,
  output logic [sgp_pkg::RemoteWordW-1:0]     rwdata_o,
  output logic [sgp_pkg::IdxW-1:0]            rraddr_o,
  input  logic [sgp_pkg::RemoteWordW-1:0]     rrdata_i
);

  localparam int unsigned IdxW  = sgp_pkg::IdxW;
  localparam int unsigned CntW  = sgp_pkg::CntW;
  localparam int unsigned AddrW = sgp_pkg::AddrW;
  localparam int unsigned LenW  = sgp_pkg::LenW;
  localparam int unsigned KeyW  = sgp_pkg::KeyW;
  localparam int unsigned DoneW = sgp_pkg::DoneW;
  localparam int unsigned AccW  = sgp_pkg::AccW;
  localparam int unsigned AluW  = sgp_pkg::AluW;

  typedef enum logic [20:0] {
    ST_IDLE   = 21'h000001,
    ST_SUM_L  = 21'h000002,
    ST_SUM_R  = 21'h000004,
    ST_MIN    = 21'h000008,
    ST_CMP    = 21'h000010,
    ST_PREF   = 21'h000020,
    ST_FIND_L = 21'h000040,
    ST_FIND_R = 21'h000080,
    ST_EMPTY  = 21'h000100,
    ST_N_LL   = 21'h000200,
    ST_N_RL   = 21'h000400,
    ST_N_MIN  = 21'h000800,
    ST_N_LIM  = 21'h001000,
    ST_N_LA   = 21'h002000,
    ST_N_RA   = 21'h004000,
    ST_N_SENT = 21'h008000,
    ST_N_LO   = 21'h010000,
    ST_N_SKL  = 21'h020000,
    ST_N_RO   = 21'h040000,
    ST_N_SKR  = 21'h080000,
    ST_N_DONE = 21'h100000
  } state_e;

  function automatic sgp_pkg::res_t stat_res(sgp_pkg::status_e s);
    sgp_pkg::res_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [CntW-1:0]   lused_q, lused_d, rused_q, rused_d;
  logic [DoneW-1:0]  tot_q, tot_d, sent_q, sent_d, done_q, done_d;
  logic [CntW-1:0]   lpos_q, lpos_d, rpos_q, rpos_d;
  logic [LenW-1:0]   loff_q, loff_d, roff_q, roff_d;
  logic              active_q, active_d, empty_q, empty_d;
  logic [CntW-1:0]   lrd_q, lrd_d, rrd_q, rrd_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [LenW-1:0]   tmp_q, tmp_d;
  sgp_pkg::res_t     out_q, out_d;
  logic              res_valid_q, res_valid_d;

  logic              accept;
  logic [CntW-1:0]   lcnt, rcnt;
  logic [LenW-1:0]   lim;
  logic [AddrW-1:0]  l_addr, r_addr;
  logic [LenW-1:0]   l_len, r_len;
  logic [KeyW-1:0]   r_key;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign lcnt = (req_i.local_count > CntW'(sgp_pkg::LocalEntries)) ?
                CntW'(sgp_pkg::LocalEntries) : req_i.local_count;
  assign rcnt = (req_i.remote_count > CntW'(sgp_pkg::RemoteEntries)) ?
                CntW'(sgp_pkg::RemoteEntries) : req_i.remote_count;
  assign lim  = (cfg_i.max_segment_len == '0) ? LenW'(1) : cfg_i.max_segment_len;

  assign l_len  = lrdata_i[LenW-1:0];
  assign l_addr = lrdata_i[LenW +: AddrW];
  assign r_len  = rrdata_i[LenW-1:0];
  assign r_addr = rrdata_i[LenW +: AddrW];
  assign r_key  = rrdata_i[LenW+AddrW +: KeyW];

  assign lwe_o    = accept && (req_i.action == sgp_pkg::ACT_LOAD_LOCAL);
  assign lwaddr_o = req_i.entry_index;
  assign lwdata_o = {req_i.entry_addr, req_i.entry_len};
  assign rwe_o    = accept && (req_i.action == sgp_pkg::ACT_LOAD_REMOTE);
  assign rwaddr_o = req_i.entry_index;
  assign rwdata_o = {req_i.entry_key, req_i.entry_addr, req_i.entry_len};
  assign lraddr_o = lrd_d[IdxW-1:0];
  assign rraddr_o = rrd_d[IdxW-1:0];

  assign res_valid_o = res_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    lused_d     = lused_q;
    rused_d     = rused_q;
    tot_d       = tot_q;
    sent_d      = sent_q;
    done_d      = done_q;
    lpos_d      = lpos_q;
    rpos_d      = rpos_q;
    loff_d      = loff_q;
    roff_d      = roff_q;
    active_d    = active_q;
    empty_d     = empty_q;
    lrd_d       = lrd_q;
    rrd_d       = rrd_q;
    acc_d       = acc_q;
    tmp_d       = tmp_q;
    out_d       = out_q;
    res_valid_d = 1'b0;
    alu_req_o.op = sgp_pkg::ALU_ADD;
    alu_req_o.a  = '0;
    alu_req_o.b  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.action)
            sgp_pkg::ACT_LOAD_LOCAL, sgp_pkg::ACT_LOAD_REMOTE: begin
            end
            sgp_pkg::ACT_START: begin
              active_d = 1'b0;
              empty_d  = 1'b0;
              lused_d  = lcnt;
              rused_d  = rcnt;
              lpos_d   = '0;
              loff_d   = '0;
              rpos_d   = '0;
              roff_d   = '0;
              tot_d    = '0;
              sent_d   = '0;
              done_d   = req_i.bytes_done;
              if (lcnt == '0 || rcnt == '0) begin
                out_d       = stat_res(sgp_pkg::STAT_RANGE);
                res_valid_d = 1'b1;
              end else begin
                acc_d   = '0;
                lrd_d   = '0;
                rrd_d   = '0;
                state_d = ST_SUM_L;
              end
            end
            sgp_pkg::ACT_NEXT: begin
              if (empty_q) begin
                empty_d = 1'b0;
                lrd_d   = '0;
                rrd_d   = '0;
                state_d = ST_EMPTY;
              end else if (!active_q) begin
                out_d       = stat_res(sgp_pkg::STAT_NONE);
                res_valid_d = 1'b1;
              end else begin
                lrd_d   = lpos_q;
                rrd_d   = rpos_q;
                out_d   = '0;
                state_d = ST_N_LL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUM_L: begin
        alu_req_o.a = AluW'(acc_q);
        alu_req_o.b = AluW'(l_len);
        if (lrd_q == lused_q - CntW'(1)) begin
          tot_d   = alu_rsp_i.res[DoneW-1:0];
          acc_d   = '0;
          state_d = ST_SUM_R;
        end else begin
          acc_d = alu_rsp_i.res[AccW-1:0];
          lrd_d = lrd_q + CntW'(1);
        end
      end
      ST_SUM_R: begin
        alu_req_o.a = AluW'(acc_q);
        alu_req_o.b = AluW'(r_len);
        acc_d = alu_rsp_i.res[AccW-1:0];
        if (rrd_q == rused_q - CntW'(1)) begin
          state_d = ST_MIN;
        end else begin
          rrd_d = rrd_q + CntW'(1);
        end
      end
      ST_MIN: begin
        alu_req_o.op = sgp_pkg::ALU_MIN;
        alu_req_o.a  = AluW'(tot_q);
        alu_req_o.b  = AluW'(acc_q);
        tot_d   = alu_rsp_i.res[DoneW-1:0];
        state_d = ST_CMP;
      end
      ST_CMP: begin
        alu_req_o.op = sgp_pkg::ALU_SUB;
        alu_req_o.a  = AluW'(done_q);
        alu_req_o.b  = AluW'(tot_q);
        if (tot_q == '0) begin
          empty_d     = 1'b1;
          out_d       = stat_res(sgp_pkg::STAT_OK);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (!alu_rsp_i.lt) begin
          out_d       = stat_res(sgp_pkg::STAT_NONE);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_PREF;
        end
      end
      ST_PREF: begin
        alu_req_o.a = AluW'(done_q);
        alu_req_o.b = AluW'(cfg_i.prefix_len);
        acc_d   = alu_rsp_i.res[AccW-1:0];
        lrd_d   = '0;
        state_d = ST_FIND_L;
      end
      ST_FIND_L: begin
        alu_req_o.op = sgp_pkg::ALU_SUB;
        alu_req_o.a  = AluW'(acc_q);
        alu_req_o.b  = AluW'(l_len);
        if (lrd_q >= lused_q) begin
          out_d       = stat_res(sgp_pkg::STAT_RANGE);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (alu_rsp_i.lt) begin
          lpos_d  = lrd_q;
          loff_d  = acc_q[LenW-1:0];
          acc_d   = AccW'(done_q);
          rrd_d   = '0;
          state_d = ST_FIND_R;
        end else begin
          acc_d = alu_rsp_i.res[AccW-1:0];
          lrd_d = lrd_q + CntW'(1);
        end
      end
      ST_FIND_R: begin
        alu_req_o.op = sgp_pkg::ALU_SUB;
        alu_req_o.a  = AluW'(acc_q);
        alu_req_o.b  = AluW'(r_len);
        if (rrd_q >= rused_q) begin
          lpos_d      = '0;
          loff_d      = '0;
          out_d       = stat_res(sgp_pkg::STAT_RANGE);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (alu_rsp_i.lt) begin
          rpos_d      = rrd_q;
          roff_d      = acc_q[LenW-1:0];
          sent_d      = done_q;
          active_d    = 1'b1;
          out_d       = stat_res(sgp_pkg::STAT_OK);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          acc_d = alu_rsp_i.res[AccW-1:0];
          rrd_d = rrd_q + CntW'(1);
        end
      end
      ST_EMPTY: begin
        out_d                 = stat_res(sgp_pkg::STAT_OK);
        out_d.seg_local_addr  = l_addr;
        out_d.seg_remote_addr = r_addr;
        out_d.seg_remote_key  = r_key;
        out_d.last_segment    = 1'b1;
        res_valid_d           = 1'b1;
        state_d               = ST_IDLE;
      end
      ST_N_LL: begin
        alu_req_o.op = sgp_pkg::ALU_SUB;
        alu_req_o.a  = AluW'(l_len);
        alu_req_o.b  = AluW'(loff_q);
        if (lpos_q >= lused_q || rpos_q >= rused_q || alu_rsp_i.lt ||
            alu_rsp_i.res == '0) begin
          active_d    = 1'b0;
          out_d       = stat_res(sgp_pkg::STAT_RANGE);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          acc_d   = alu_rsp_i.res[AccW-1:0];
          state_d = ST_N_RL;
        end
      end
      ST_N_RL: begin
        alu_req_o.op = sgp_pkg::ALU_SUB;
        alu_req_o.a  = AluW'(r_len);
        alu_req_o.b  = AluW'(roff_q);
        if (alu_rsp_i.lt || alu_rsp_i.res == '0) begin
          active_d    = 1'b0;
          out_d       = stat_res(sgp_pkg::STAT_RANGE);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          tmp_d   = alu_rsp_i.res[LenW-1:0];
          state_d = ST_N_MIN;
        end
      end
      ST_N_MIN: begin
        alu_req_o.op = sgp_pkg::ALU_MIN;
        alu_req_o.a  = AluW'(acc_q);
        alu_req_o.b  = AluW'(tmp_q);
        acc_d   = alu_rsp_i.res[AccW-1:0];
        state_d = ST_N_LIM;
      end
      ST_N_LIM: begin
        alu_req_o.op = sgp_pkg::ALU_MIN;
        alu_req_o.a  = AluW'(acc_q);
        alu_req_o.b  = AluW'(lim);
        acc_d   = alu_rsp_i.res[AccW-1:0];
        state_d = ST_N_LA;
      end
      ST_N_LA: begin
        alu_req_o.a = l_addr;
        alu_req_o.b = AluW'(loff_q);
        out_d.seg_local_addr  = alu_rsp_i.res[AddrW-1:0];
        out_d.seg_local_entry = lpos_q[IdxW-1:0];
        out_d.seg_len         = acc_q[LenW-1:0];
        state_d               = ST_N_RA;
      end
      ST_N_RA: begin
        alu_req_o.a = r_addr;
        alu_req_o.b = AluW'(roff_q);
        out_d.seg_remote_addr = alu_rsp_i.res[AddrW-1:0];
        out_d.seg_remote_key  = r_key;
        state_d               = ST_N_SENT;
      end
      ST_N_SENT: begin
        alu_req_o.a = AluW'(sent_q);
        alu_req_o.b = AluW'(acc_q);
        sent_d  = alu_rsp_i.res[DoneW-1:0];
        state_d = ST_N_LO;
      end
      ST_N_LO: begin
        alu_req_o.a = AluW'(loff_q);
        alu_req_o.b = AluW'(acc_q);
        if (alu_rsp_i.res[LenW:0] == {1'b0, l_len}) begin
          loff_d  = '0;
          lrd_d   = lrd_q + CntW'(1);
          state_d = ST_N_SKL;
        end else begin
          loff_d  = alu_rsp_i.res[LenW-1:0];
          state_d = ST_N_RO;
        end
      end
      ST_N_SKL: begin
        if (lrd_q >= lused_q || l_len != '0) begin
          lpos_d  = lrd_q;
          state_d = ST_N_RO;
        end else begin
          lrd_d = lrd_q + CntW'(1);
        end
      end
      ST_N_RO: begin
        alu_req_o.a = AluW'(roff_q);
        alu_req_o.b = AluW'(acc_q);
        if (alu_rsp_i.res[LenW:0] == {1'b0, r_len}) begin
          roff_d  = '0;
          rrd_d   = rrd_q + CntW'(1);
          state_d = ST_N_SKR;
        end else begin
          roff_d  = alu_rsp_i.res[LenW-1:0];
          state_d = ST_N_DONE;
        end
      end
      ST_N_SKR: begin
        if (rrd_q >= rused_q || r_len != '0) begin
          rpos_d  = rrd_q;
          state_d = ST_N_DONE;
        end else begin
          rrd_d = rrd_q + CntW'(1);
        end
      end
      ST_N_DONE: begin
        alu_req_o.op = sgp_pkg::ALU_SUB;
        alu_req_o.a  = AluW'(sent_q);
        alu_req_o.b  = AluW'(tot_q);
        out_d.status = sgp_pkg::STAT_OK;
        if (!alu_rsp_i.lt) begin
          active_d           = 1'b0;
          out_d.last_segment = 1'b1;
        end
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lused_q     <= '0;
      rused_q     <= '0;
      tot_q       <= '0;
      sent_q      <= '0;
      lpos_q      <= '0;
      rpos_q      <= '0;
      loff_q      <= '0;
      roff_q      <= '0;
      active_q    <= 1'b0;
      empty_q     <= 1'b0;
      lrd_q       <= '0;
      rrd_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lused_q     <= lused_d;
      rused_q     <= rused_d;
      tot_q       <= tot_d;
      sent_q      <= sent_d;
      lpos_q      <= lpos_d;
      rpos_q      <= rpos_d;
      loff_q      <= loff_d;
      roff_q      <= roff_d;
      active_q    <= active_d;
      empty_q     <= empty_d;
      lrd_q       <= lrd_d;
      rrd_q       <= rrd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    acc_q  <= acc_d;
    tmp_q  <= tmp_d;
    out_q  <= out_d;
  end

  // a result always ends the current request
  `SGP_ASSERT(a_res_idle, res_valid_o |-> !busy_o, "result while sequencer busy")
  `SGP_ASSERT(a_pos_range, (lpos_q <= lused_q) && (rpos_q <= rused_q), "position past list")
  `SGP_ASSERT(a_empty_idle, !(empty_q && active_q), "empty read pending while active")
  `SGP_ASSERT_NEXT(a_zero_cnt,
    accept && (req_i.action == sgp_pkg::ACT_START) && (req_i.local_count == '0),
    res_valid_o && (res_o.status == sgp_pkg::STAT_RANGE), "zero count start not rejected")

endmodule

// ===== tb/tb_top.sv =====
// testbench for sg_pair_read_segmenter: directed and random requests through the start/busy
// port, register writes while idle, every result checked against a built-in segment predictor
// depends on sgp_pkg and the segmenter rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned ItemTarget = 1300;
  localparam bit [63:0] Mask36 = 64'hF_FFFF_FFFF;

  class segment_scoreboard;
    bit [sgp_pkg::AddrW-1:0] l_addr [sgp_pkg::LocalEntries];
    bit [sgp_pkg::LenW-1:0]  l_len  [sgp_pkg::LocalEntries];
    bit [sgp_pkg::AddrW-1:0] r_addr [sgp_pkg::RemoteEntries];
    bit [sgp_pkg::LenW-1:0]  r_len  [sgp_pkg::RemoteEntries];
    bit [sgp_pkg::KeyW-1:0]  r_key  [sgp_pkg::RemoteEntries];
    bit [sgp_pkg::CntW-1:0]  l_used, r_used, l_pos, r_pos;
    bit [sgp_pkg::LenW-1:0]  l_off, r_off;
    bit [sgp_pkg::DoneW-1:0] total, sent;
    bit                      on_air, zero_pending;
    bit [sgp_pkg::LenW-1:0]  max_seg = '1;
    bit [sgp_pkg::PrefW-1:0] prefix = '0;
    sgp_pkg::res_t           pending_segments[$];
    int                      errors = 0;
    int                      seen = 0;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void write_reg(sgp_pkg::cfg_idx_e idx, bit [sgp_pkg::LenW-1:0] val);
      if (idx == sgp_pkg::CFG_MAX_SEG) max_seg = val;
      else prefix = val[sgp_pkg::PrefW-1:0];
    endfunction

    function bit [sgp_pkg::CntW-1:0] clamp(bit [sgp_pkg::CntW-1:0] c, int unsigned depth);
      return (c > depth) ? sgp_pkg::CntW'(depth) : c;
    endfunction

    function bit [sgp_pkg::LenW-1:0] len_at(bit remote, bit [sgp_pkg::CntW-1:0] i);
      return remote ? r_len[i[sgp_pkg::IdxW-1:0]] : l_len[i[sgp_pkg::IdxW-1:0]];
    endfunction

    function bit [63:0] list_total(bit remote, bit [sgp_pkg::CntW-1:0] n);
      bit [63:0] s;
      s = '0;
      for (int i = 0; i < n; i++) s += 64'(len_at(remote, sgp_pkg::CntW'(i)));
      return s;
    endfunction

    function bit [63:0] total_for(bit [sgp_pkg::CntW-1:0] lc, bit [sgp_pkg::CntW-1:0] rc);
      bit [63:0] ls, rs, t;
      ls = list_total(1'b0, clamp(lc, sgp_pkg::LocalEntries));
      rs = list_total(1'b1, clamp(rc, sgp_pkg::RemoteEntries));
      t = (ls < rs) ? ls : rs;
      if (t > Mask36) t = Mask36;
      return t;
    endfunction

    function bit locate(bit remote, bit [sgp_pkg::CntW-1:0] n, bit [63:0] where,
                        output bit [sgp_pkg::CntW-1:0] idx,
                        output bit [sgp_pkg::LenW-1:0] off);
      bit [63:0] base;
      base = '0;
      idx = '0;
      off = '0;
      for (int i = 0; i < n; i++) begin
        if (where >= base && where < base + 64'(len_at(remote, sgp_pkg::CntW'(i)))) begin
          idx = sgp_pkg::CntW'(i);
          off = sgp_pkg::LenW'(where - base);
          return 1'b1;
        end
        base += 64'(len_at(remote, sgp_pkg::CntW'(i)));
      end
      return 1'b0;
    endfunction

    function bit [sgp_pkg::CntW-1:0] skip_zero(bit remote, bit [sgp_pkg::CntW-1:0] i,
                                               bit [sgp_pkg::CntW-1:0] n);
      while (i < n && len_at(remote, i) == '0) i++;
      return i;
    endfunction

    function sgp_pkg::res_t predict(sgp_pkg::req_t q, output bit has);
      sgp_pkg::res_t r;
      bit [63:0] lleft, rleft, lim, n;
      r = '0;
      has = 1'b0;
      case (q.action)
        sgp_pkg::ACT_LOAD_LOCAL: begin
          l_addr[q.entry_index] = q.entry_addr;
          l_len[q.entry_index] = q.entry_len;
        end
        sgp_pkg::ACT_LOAD_REMOTE: begin
          r_addr[q.entry_index] = q.entry_addr;
          r_len[q.entry_index] = q.entry_len;
          r_key[q.entry_index] = q.entry_key;
        end
        sgp_pkg::ACT_START: begin
          has = 1'b1;
          on_air = 1'b0;
          zero_pending = 1'b0;
          l_used = clamp(q.local_count, sgp_pkg::LocalEntries);
          r_used = clamp(q.remote_count, sgp_pkg::RemoteEntries);
          l_pos = '0; l_off = '0;
          r_pos = '0; r_off = '0;
          total = '0;
          sent = '0;
          if (l_used == '0 || r_used == '0) begin
            r.status = sgp_pkg::STAT_RANGE;
          end else begin
            total = sgp_pkg::DoneW'(total_for(q.local_count, q.remote_count));
            if (total == '0) begin
              zero_pending = 1'b1;
              r.status = sgp_pkg::STAT_OK;
            end else if (q.bytes_done >= total) begin
              r.status = sgp_pkg::STAT_NONE;
            end else if (!locate(1'b0, l_used, 64'(q.bytes_done) + 64'(prefix), l_pos,
                                 l_off) ||
                         !locate(1'b1, r_used, 64'(q.bytes_done), r_pos, r_off)) begin
              l_pos = '0; l_off = '0;
              r_pos = '0; r_off = '0;
              r.status = sgp_pkg::STAT_RANGE;
            end else begin
              sent = q.bytes_done;
              on_air = 1'b1;
              r.status = sgp_pkg::STAT_OK;
            end
          end
        end
        default: begin
          has = 1'b1;
          if (zero_pending) begin
            zero_pending = 1'b0;
            r.status = sgp_pkg::STAT_OK;
            r.seg_local_addr = l_addr[0];
            r.seg_remote_addr = r_addr[0];
            r.seg_remote_key = r_key[0];
            r.last_segment = 1'b1;
          end else if (!on_air) begin
            r.status = sgp_pkg::STAT_NONE;
          end else if (l_pos >= l_used || r_pos >= r_used ||
                       l_off >= len_at(1'b0, l_pos) || r_off >= len_at(1'b1, r_pos)) begin
            on_air = 1'b0;
            r.status = sgp_pkg::STAT_RANGE;
          end else begin
            lleft = 64'(len_at(1'b0, l_pos)) - 64'(l_off);
            rleft = 64'(len_at(1'b1, r_pos)) - 64'(r_off);
            lim = (max_seg == '0) ? 64'd1 : 64'(max_seg);
            n = (lleft < rleft) ? lleft : rleft;
            if (n > lim) n = lim;
            r.status = sgp_pkg::STAT_OK;
            r.seg_local_addr = l_addr[l_pos[sgp_pkg::IdxW-1:0]] + 64'(l_off);
            r.seg_local_entry = l_pos[sgp_pkg::IdxW-1:0];
            r.seg_remote_addr = r_addr[r_pos[sgp_pkg::IdxW-1:0]] + 64'(r_off);
            r.seg_remote_key = r_key[r_pos[sgp_pkg::IdxW-1:0]];
            r.seg_len = n[sgp_pkg::LenW-1:0];
            sent = sgp_pkg::DoneW'(64'(sent) + n);
            l_off = sgp_pkg::LenW'(64'(l_off) + n);
            if (l_off >= len_at(1'b0, l_pos)) begin
              l_pos++;
              l_off = '0;
              l_pos = skip_zero(1'b0, l_pos, l_used);
            end
            r_off = sgp_pkg::LenW'(64'(r_off) + n);
            if (r_off >= len_at(1'b1, r_pos)) begin
              r_pos++;
              r_off = '0;
              r_pos = skip_zero(1'b1, r_pos, r_used);
            end
            if (sent >= total) begin
              on_air = 1'b0;
              r.last_segment = 1'b1;
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(sgp_pkg::req_t q);
      sgp_pkg::res_t r;
      bit has;
      r = predict(q, has);
      if (has) pending_segments.push_back(r);
    endfunction

    task check_segment(sgp_pkg::res_t got);
      sgp_pkg::res_t want;
      string bad;
      if (pending_segments.size() == 0) begin
        report($sformatf("result with no request waiting: %h", got));
        return;
      end
      want = pending_segments.pop_front();
      seen++;
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.seg_local_addr !== want.seg_local_addr) bad = {bad, " seg_local_addr"};
      if (got.seg_local_entry !== want.seg_local_entry) bad = {bad, " seg_local_entry"};
      if (got.seg_remote_addr !== want.seg_remote_addr) bad = {bad, " seg_remote_addr"};
      if (got.seg_remote_key !== want.seg_remote_key) bad = {bad, " seg_remote_key"};
      if (got.seg_len !== want.seg_len) bad = {bad, " seg_len"};
      if (got.last_segment !== want.last_segment) bad = {bad, " last_segment"};
      if (bad != "") report($sformatf("result %0d:%s got %h want %h", seen, bad, got, want));
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  sgp_pkg::req_t               req = '0;
  logic                        res_valid;
  sgp_pkg::res_t               seg_res;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [sgp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sgp_pkg::LenW-1:0]    cfg_data = '0;

  segment_scoreboard sb = new();
  int  items = 0;
  int  quiet = 0;
  bit  burst = 1'b0;

  sg_pair_read_segmenter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (seg_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid === 1'b1) sb.check_segment(seg_res);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || res_valid === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sgp_pkg::req_t any_request(sgp_pkg::action_e a);
    sgp_pkg::req_t q;
    q.action = a;
    q.entry_index = sgp_pkg::IdxW'($urandom_range(0, 15));
    q.entry_addr = rand64();
    q.entry_len = $urandom();
    q.entry_key = rand64();
    q.local_count = sgp_pkg::CntW'($urandom_range(0, 31));
    q.remote_count = sgp_pkg::CntW'($urandom_range(0, 31));
    q.bytes_done = sgp_pkg::DoneW'(rand64());
    return q;
  endfunction

  function automatic bit [sgp_pkg::LenW-1:0] pick_len();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return $urandom();
      2: return '1;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic bit [sgp_pkg::CntW-1:0] pick_count();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return sgp_pkg::CntW'($urandom_range(17, 31));
      default: return sgp_pkg::CntW'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_item(sgp_pkg::req_t q);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req <= q;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(q);
    items++;
  endtask

  task automatic write_reg(sgp_pkg::cfg_idx_e idx, logic [sgp_pkg::LenW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_segments.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_entry(bit remote, int idx, bit [63:0] addr,
                            bit [sgp_pkg::LenW-1:0] len, bit [63:0] key);
    sgp_pkg::req_t q;
    q = any_request(remote ? sgp_pkg::ACT_LOAD_REMOTE : sgp_pkg::ACT_LOAD_LOCAL);
    q.entry_index = sgp_pkg::IdxW'(idx);
    q.entry_addr = addr;
    q.entry_len = len;
    q.entry_key = key;
    send_item(q);
  endtask

  task automatic start_walk(bit [sgp_pkg::CntW-1:0] lc, bit [sgp_pkg::CntW-1:0] rc,
                            bit [sgp_pkg::DoneW-1:0] done);
    sgp_pkg::req_t q;
    q = any_request(sgp_pkg::ACT_START);
    q.local_count = lc;
    q.remote_count = rc;
    q.bytes_done = done;
    send_item(q);
  endtask

  task automatic step_segment();
    send_item(any_request(sgp_pkg::ACT_NEXT));
  endtask

  task automatic new_settings();
    bit [sgp_pkg::LenW-1:0] ms, pf;
    int which;
    settle();
    case ($urandom_range(0, 4))
      0: ms = '0;
      1: ms = 1;
      2: ms = '1;
      3: ms = $urandom_range(1, 64);
      default: ms = $urandom();
    endcase
    case ($urandom_range(0, 6))
      0: pf = 4096;
      1: pf = $urandom_range(0, 64);
      2: pf = $urandom_range(0, 4096);
      3: pf = $urandom();
      default: pf = '0;
    endcase
    which = $urandom_range(0, 2);
    if (which != 1) write_reg(sgp_pkg::CFG_MAX_SEG, ms);
    if (which != 0) write_reg(sgp_pkg::CFG_PREFIX, pf);
  endtask

  initial begin
    bit [63:0] t;
    bit [sgp_pkg::DoneW-1:0] done;
    bit [sgp_pkg::CntW-1:0] lc, rc;
    int c;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle and empty-list cases first, touching no table entry
    step_segment();
    start_walk(0, 5, 0);
    load_entry(0, 0, '1, 100, rand64());
    load_entry(0, 1, rand64(), 0, rand64());
    load_entry(0, 2, '0, 200, rand64());
    load_entry(1, 0, '0, 150, '1);
    load_entry(1, 1, '1, '1, '0);
    start_walk(3, 0, 0);
    start_walk(3, 2, 0);
    repeat (4) step_segment();
    start_walk(3, 2, 300);
    start_walk(3, 2, 120);
    step_segment();
    // shrink the local entry in use below its offset, then step, which reports a range status
    load_entry(0, 2, rand64(), 10, rand64());
    step_segment();
    settle();
    write_reg(sgp_pkg::CFG_MAX_SEG, '0);
    write_reg(sgp_pkg::CFG_PREFIX, 4096);
    start_walk(3, 2, 0);
    settle();
    write_reg(sgp_pkg::CFG_PREFIX, 5);
    start_walk(3, 2, 0);
    step_segment();
    load_entry(0, 0, rand64(), 0, rand64());
    start_walk(2, 1, 0);
    step_segment();
    step_segment();
    settle();
    write_reg(sgp_pkg::CFG_MAX_SEG, '1);
    write_reg(sgp_pkg::CFG_PREFIX, 0);

    // random: fill both lists, then mostly well-formed read sequences
    for (int i = 0; i < sgp_pkg::LocalEntries; i++) begin
      burst = ($urandom_range(0, 3) == 0);
      load_entry(0, i, rand64(), pick_len(), rand64());
      load_entry(1, i, rand64(), pick_len(), rand64());
    end
    while (items < ItemTarget) begin
      burst = ($urandom_range(0, 3) == 0);
      c = $urandom_range(0, 11);
      if (c == 0) begin
        new_settings();
      end else if (c == 1) begin
        repeat ($urandom_range(1, 4))
          send_item(any_request(sgp_pkg::action_e'($urandom_range(0, 3))));
      end else begin
        repeat ($urandom_range(0, 3))
          load_entry(1'($urandom_range(0, 1)), $urandom_range(0, 15), rand64(), pick_len(),
                     rand64());
        lc = pick_count();
        rc = pick_count();
        t = sb.total_for(lc, rc);
        c = $urandom_range(0, 7);
        if (t == 0 || c == 0) done = sgp_pkg::DoneW'(rand64());
        else if (c == 1) done = sgp_pkg::DoneW'(t);
        else done = sgp_pkg::DoneW'(rand64() % t);
        start_walk(lc, rc, done);
        for (int k = 0; k < 48; k++) begin
          if ($urandom_range(0, 19) == 0)
            load_entry(1'($urandom_range(0, 1)), $urandom_range(0, 15), rand64(), pick_len(),
                       rand64());
          if ($urandom_range(0, 29) == 0) break;
          step_segment();
          if (!sb.on_air && !sb.zero_pending) break;
        end
        if ($urandom_range(0, 3) == 0) step_segment();
      end
    end

    settle();
    if (sb.pending_segments.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_segments.size()));
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
